[hw/rtl/rbgk_pkg.sv]
// Package for the D2Q9 regularized BGK collision unit: payload types, Q4.28 constants,
// lattice tables and the saturating fixed-point helpers. No dependencies.
package rbgk_pkg;

   localparam int DW       = 32;          // data width
   localparam int FB       = 28;          // fraction bits
   localparam int RATE_W   = 30;          // relax rate register width
   localparam int NUM_DIR  = 9;
   localparam int NUM_MOM  = 6;
   localparam int LOWB     = DW - FB;     // integer bits consumed by the divider

   localparam int MOM_LAT  = 3;
   localparam int DIV_STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES = DW / DIV_STEPS_PER_STAGE;
   localparam int DIV_LAT  = DIV_STAGES + 2;
   localparam int COL_LAT  = 10;
   localparam int TOTAL_LAT = MOM_LAT + DIV_LAT + COL_LAT;

   // moment indexes
   localparam int M00 = 0;
   localparam int M10 = 1;
   localparam int M01 = 2;
   localparam int M11 = 3;
   localparam int M20 = 4;
   localparam int M02 = 5;

   typedef logic signed [DW-1:0]   data_type;
   typedef logic signed [2*DW-1:0] prod_type;
   typedef data_type [NUM_DIR-1:0] dist_type;
   typedef data_type [NUM_MOM-1:0] mom_type;

   typedef struct packed {
      logic     is_fluid;
      data_type dist_rest;
      data_type dist_east;
      data_type dist_north;
      data_type dist_west;
      data_type dist_south;
      data_type dist_ne;
      data_type dist_nw;
      data_type dist_sw;
      data_type dist_se;
   } req_type;

   typedef struct packed {
      logic     written;
      data_type post_rest;
      data_type post_east;
      data_type post_north;
      data_type post_west;
      data_type post_south;
      data_type post_ne;
      data_type post_nw;
      data_type post_sw;
      data_type post_se;
   } rsp_type;

   localparam data_type MAXV  = {1'b0, {(DW-1){1'b1}}};
   localparam data_type MINV  = {1'b1, {(DW-1){1'b0}}};
   localparam data_type ONE   = 32'sd268435456;
   localparam data_type THREE = 32'sd805306368;
   localparam data_type C45   = 32'sd1207959552;
   localparam data_type C15   = 32'sd402653184;
   localparam data_type THIRD = 32'sd89478485;
   localparam data_type Q23   = 32'sd178956971;    // 1 - 1/3
   localparam data_type QM13  = -32'sd89478485;    // -1/3
   localparam data_type W_REST = 32'sd119304647;
   localparam data_type W_AXIS = 32'sd29826162;
   localparam data_type W_DIAG = 32'sd7456540;
   localparam data_type K_REST = 32'sd536870912;   // 4.5 * w
   localparam data_type K_AXIS = 32'sd134217728;
   localparam data_type K_DIAG = 32'sd33554432;
   localparam data_type KEEP_RESET = '0;           // 1 - omega at omega = 1.0

   // order: rest, E, N, W, S, NE, NW, SW, SE
   localparam int DIR_X [NUM_DIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
   localparam int DIR_Y [NUM_DIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};

   function automatic data_type sat_add(data_type a, data_type b);
      logic [DW:0] s;
      s = {a[DW-1], a} + {b[DW-1], b};
      if (s[DW] != s[DW-1]) return s[DW] ? MINV : MAXV;
      return data_type'(s[DW-1:0]);
   endfunction

   function automatic data_type sat_sub(data_type a, data_type b);
      logic [DW:0] s;
      s = {a[DW-1], a} - {b[DW-1], b};
      if (s[DW] != s[DW-1]) return s[DW] ? MINV : MAXV;
      return data_type'(s[DW-1:0]);
   endfunction

   // c > 0 adds, c < 0 subtracts, 0 keeps
   function automatic data_type acc_step(data_type acc, data_type f, int c);
      if (c > 0) return sat_add(acc, f);
      if (c < 0) return sat_sub(acc, f);
      return acc;
   endfunction

   function automatic prod_type mul_raw(data_type a, data_type b);
      return a * b;
   endfunction

   // round half away from zero on the magnitude, then saturate
   function automatic data_type mul_fin(prod_type p);
      logic [2*DW-1:0]  m;
      logic [2*DW-1:0]  t;
      logic [2*DW-FB-1:0] r;
      logic [DW-1:0]    rl;
      m  = p[2*DW-1] ? -p : p;
      t  = m + ((2*DW)'(1) << (FB-1));
      r  = t[2*DW-1:FB];
      rl = r[DW-1:0];
      if (p[2*DW-1]) begin
         if (r > ((2*DW-FB)'(1) << (DW-1))) return MINV;
         return data_type'(~rl + 1'b1);
      end
      if (r > ((2*DW-FB)'(1) << (DW-1)) - 1'b1) return MAXV;
      return data_type'(rl);
   endfunction

   // one restoring step: returns {quotient bit, new remainder}
   function automatic logic [DW:0] div_step(logic [DW-1:0] rem, logic nb,
                                            logic [DW-1:0] ud);
      logic [DW:0] t;
      logic [DW:0] d;
      t = {rem, nb};
      d = t - {1'b0, ud};
      if (t >= {1'b0, ud}) return {1'b1, d[DW-1:0]};
      return {1'b0, t[DW-1:0]};
   endfunction

   function automatic int mom_coef(int j, int q);
      case (j)
         M00:     return 1;
         M10:     return DIR_X[q];
         M01:     return DIR_Y[q];
         M11:     return DIR_X[q] * DIR_Y[q];
         M20:     return (DIR_X[q] != 0) ? 1 : 0;
         M02:     return (DIR_Y[q] != 0) ? 1 : 0;
         default: return 0;
      endcase
   endfunction

   function automatic data_type weight(int q);
      if (q == 0) return W_REST;
      if (q < 5) return W_AXIS;
      return W_DIAG;
   endfunction

   function automatic data_type kfac(int q);
      if (q == 0) return K_REST;
      if (q < 5) return K_AXIS;
      return K_DIAG;
   endfunction

   function automatic dist_type cell_dist(req_type c);
      dist_type f;
      f[0] = c.dist_rest;  f[1] = c.dist_east; f[2] = c.dist_north;
      f[3] = c.dist_west;  f[4] = c.dist_south; f[5] = c.dist_ne;
      f[6] = c.dist_nw;    f[7] = c.dist_sw;   f[8] = c.dist_se;
      return f;
   endfunction

   function automatic rsp_type make_rsp(logic wr, dist_type p);
      rsp_type r;
      r.written   = wr;
      r.post_rest = p[0]; r.post_east  = p[1]; r.post_north = p[2];
      r.post_west = p[3]; r.post_south = p[4]; r.post_ne    = p[5];
      r.post_nw   = p[6]; r.post_sw    = p[7]; r.post_se    = p[8];
      return r;
   endfunction

endpackage

[hw/rtl/rbgk_moments.sv]
// Moment accumulation: density, momentum and second moments over three stages,
// three directions per stage in lattice order. Depends on rbgk_pkg.
module rbgk_moments import rbgk_pkg::*; (
   input  logic    clock,
   input  logic    en,
   input  req_type cell_in,
   output mom_type mom_out,
   output req_type cell_out
);

   mom_type acc_ff [MOM_LAT];
   mom_type acc_in [MOM_LAT];
   req_type cell_ff [MOM_LAT];

   always_comb begin
      data_type a;
      dist_type f;
      mom_type  base;
      for (int k = 0; k < MOM_LAT; k++) begin
         base = (k == 0) ? mom_type'('0) : acc_ff[(k == 0) ? 0 : k-1];
         f    = cell_dist((k == 0) ? cell_in : cell_ff[(k == 0) ? 0 : k-1]);
         for (int j = 0; j < NUM_MOM; j++) begin
            a = base[j];
            for (int i = 0; i < 3; i++) begin
               a = acc_step(a, f[3*k+i], mom_coef(j, 3*k+i));
            end
            acc_in[k][j] = a;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         acc_ff[0]  <= acc_in[0];
         cell_ff[0] <= cell_in;
         for (int k = 1; k < MOM_LAT; k++) begin
            acc_ff[k]  <= acc_in[k];
            cell_ff[k] <= cell_ff[k-1];
         end
      end
   end

   assign mom_out  = acc_ff[MOM_LAT-1];
   assign cell_out = cell_ff[MOM_LAT-1];

endmodule

[hw/rtl/rbgk_divider.sv]
// Pipelined fixed-point divider (num << FB) / den, truncated and saturated,
// two restoring steps per stage. Depends on rbgk_pkg.
module rbgk_divider import rbgk_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  data_type num,
   input  data_type den,
   output data_type quo
);

   logic [DW-1:0]   rem_ff [DIV_STAGES+1];
   logic [DW-1:0]   rem_in [DIV_STAGES+1];
   logic [DW-1:0]   q_ff   [DIV_STAGES+1];
   logic [DW-1:0]   q_in   [DIV_STAGES+1];
   logic [LOWB-1:0] low_ff [DIV_STAGES+1];
   logic [LOWB-1:0] low_in [DIV_STAGES+1];
   logic [DW-1:0]   ud_ff  [DIV_STAGES+1];
   logic            neg_ff [DIV_STAGES+1];
   logic            fix_ff [DIV_STAGES+1];
   data_type        fixv_ff [DIV_STAGES+1];
   logic            neg_in, fix_in;
   data_type        fixv_in;
   logic [DW-1:0]   ud_in;
   data_type        quo_ff, quo_in;

   // setup: magnitudes, zero divisor and quotients that cannot fit,
   // then the restoring steps of every stage
   always_comb begin
      logic [DW-1:0]   un;
      logic [DW-1:0]   r;
      logic [DW-1:0]   q;
      logic [LOWB-1:0] l;
      logic [DW:0]     st;
      un      = num[DW-1] ? -num : num;
      ud_in   = den[DW-1] ? -den : den;
      neg_in  = num[DW-1] ^ den[DW-1];
      fix_in  = 1'b0;
      fixv_in = '0;
      if (den == '0) begin
         fix_in  = 1'b1;
         fixv_in = (num == '0) ? data_type'('0) : (num[DW-1] ? MINV : MAXV);
      end else if ({{LOWB{1'b0}}, un} >= {ud_in, {LOWB{1'b0}}}) begin
         fix_in  = 1'b1;
         fixv_in = neg_in ? MINV : MAXV;
      end
      rem_in[0] = un >> LOWB;
      low_in[0] = un[LOWB-1:0];
      q_in[0]   = '0;
      for (int s = 0; s < DIV_STAGES; s++) begin
         r = rem_ff[s];
         q = q_ff[s];
         l = low_ff[s];
         for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
            st = div_step(r, l[LOWB-1], ud_ff[s]);
            r  = st[DW-1:0];
            q  = {q[DW-2:0], st[DW]};
            l  = l << 1;
         end
         rem_in[s+1] = r;
         q_in[s+1]   = q;
         low_in[s+1] = l;
      end
   end

   always_comb begin
      logic [DW-1:0] qf;
      qf = q_ff[DIV_STAGES];
      if (fix_ff[DIV_STAGES]) begin
         quo_in = fixv_ff[DIV_STAGES];
      end else if (neg_ff[DIV_STAGES]) begin
         quo_in = (qf > {1'b1, {(DW-1){1'b0}}}) ? MINV : data_type'(~qf + 1'b1);
      end else begin
         quo_in = qf[DW-1] ? MAXV : data_type'(qf);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= rem_in[0];
         q_ff[0]    <= q_in[0];
         low_ff[0]  <= low_in[0];
         ud_ff[0]   <= ud_in;
         neg_ff[0]  <= neg_in;
         fix_ff[0]  <= fix_in;
         fixv_ff[0] <= fixv_in;
         for (int s = 1; s <= DIV_STAGES; s++) begin
            rem_ff[s]  <= rem_in[s];
            q_ff[s]    <= q_in[s];
            low_ff[s]  <= low_in[s];
            ud_ff[s]   <= ud_ff[s-1];
            neg_ff[s]  <= neg_ff[s-1];
            fix_ff[s]  <= fix_ff[s-1];
            fixv_ff[s] <= fixv_ff[s-1];
         end
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

[hw/rtl/rbgk_collide.sv]
// Equilibrium, regularized non-equilibrium part and relaxation for all nine
// directions, ten stages with one multiply level per stage pair. Depends on rbgk_pkg.
module rbgk_collide import rbgk_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  data_type ux,
   input  data_type uy,
   input  mom_type  mom,
   input  data_type keep,
   input  req_type  site,
   output rsp_type  rsp
);

   mom_type  mom_ff [6];
   // stage 1
   prod_type p1_ff [3];
   data_type ux1_ff, uy1_ff;
   // stage 2
   data_type uu2_ff, axx2_ff, ayy2_ff, uxy2_ff;
   dist_type eu2_ff;
   // stage 3
   prod_type r3_ff [4];
   prod_type e3a_ff [NUM_DIR];
   prod_type e3b_ff [NUM_DIR];
   // stage 4
   data_type pxx4_ff, pxy4_ff, pyy4_ff, t15_4_ff;
   dist_type t4_ff, e2_4_ff;
   // stage 5
   prod_type c45_5_ff [NUM_DIR];
   prod_type qp5_ff [4];
   dist_type t5_ff;
   data_type t15_5_ff, pxy5_ff;
   // stage 6
   dist_type t6_ff, s6_ff;
   // stage 7
   prod_type ms7_ff [NUM_DIR];
   prod_type fk7_ff [NUM_DIR];
   // stage 8
   dist_type ms8_ff, f1_8_ff;
   // stage 9
   prod_type w9_ff [NUM_DIR];
   prod_type kf9_ff [NUM_DIR];
   // output
   rsp_type  rsp_ff, rsp_in;
   dist_type post;

   always_comb begin
      for (int q = 0; q < NUM_DIR; q++) begin
         post[q] = sat_add(mul_fin(w9_ff[q]), mul_fin(kf9_ff[q]));
      end
      rsp_in = site.is_fluid ? make_rsp(1'b1, post) : make_rsp(1'b0, cell_dist(site));
   end

   always_ff @(posedge clock) begin
      data_type uxx, uyy, uxy, sq;
      if (en) begin
         mom_ff[0] <= mom;
         for (int k = 1; k < 6; k++) mom_ff[k] <= mom_ff[k-1];

         p1_ff[0] <= mul_raw(ux, ux);
         p1_ff[1] <= mul_raw(uy, uy);
         p1_ff[2] <= mul_raw(ux, uy);
         ux1_ff   <= ux;
         uy1_ff   <= uy;

         uxx = mul_fin(p1_ff[0]);
         uyy = mul_fin(p1_ff[1]);
         uxy = mul_fin(p1_ff[2]);
         uu2_ff  <= sat_add(uxx, uyy);
         axx2_ff <= sat_add(uxx, THIRD);
         ayy2_ff <= sat_add(uyy, THIRD);
         uxy2_ff <= uxy;
         for (int q = 0; q < NUM_DIR; q++) begin
            eu2_ff[q] <= acc_step(acc_step('0, ux1_ff, DIR_X[q]), uy1_ff, DIR_Y[q]);
         end

         r3_ff[0] <= mul_raw(mom_ff[1][M00], axx2_ff);
         r3_ff[1] <= mul_raw(mom_ff[1][M00], uxy2_ff);
         r3_ff[2] <= mul_raw(mom_ff[1][M00], ayy2_ff);
         r3_ff[3] <= mul_raw(C15, uu2_ff);
         for (int q = 0; q < NUM_DIR; q++) begin
            e3a_ff[q] <= mul_raw(THREE, eu2_ff[q]);
            e3b_ff[q] <= mul_raw(eu2_ff[q], eu2_ff[q]);
         end

         pxx4_ff  <= sat_sub(mom_ff[2][M20], mul_fin(r3_ff[0]));
         pxy4_ff  <= sat_sub(mom_ff[2][M11], mul_fin(r3_ff[1]));
         pyy4_ff  <= sat_sub(mom_ff[2][M02], mul_fin(r3_ff[2]));
         t15_4_ff <= mul_fin(r3_ff[3]);
         for (int q = 0; q < NUM_DIR; q++) begin
            t4_ff[q]   <= sat_add(ONE, mul_fin(e3a_ff[q]));
            e2_4_ff[q] <= mul_fin(e3b_ff[q]);
         end

         qp5_ff[0] <= mul_raw(Q23, pxx4_ff);
         qp5_ff[1] <= mul_raw(QM13, pxx4_ff);
         qp5_ff[2] <= mul_raw(Q23, pyy4_ff);
         qp5_ff[3] <= mul_raw(QM13, pyy4_ff);
         t5_ff     <= t4_ff;
         t15_5_ff  <= t15_4_ff;
         pxy5_ff   <= pxy4_ff;
         for (int q = 0; q < NUM_DIR; q++) c45_5_ff[q] <= mul_raw(C45, e2_4_ff[q]);

         for (int q = 0; q < NUM_DIR; q++) begin
            t6_ff[q] <= sat_sub(sat_add(t5_ff[q], mul_fin(c45_5_ff[q])), t15_5_ff);
            sq = sat_add(mul_fin((DIR_X[q] != 0) ? qp5_ff[0] : qp5_ff[1]),
                         mul_fin((DIR_Y[q] != 0) ? qp5_ff[2] : qp5_ff[3]));
            // cross term counts twice
            s6_ff[q] <= acc_step(acc_step(sq, pxy5_ff, DIR_X[q] * DIR_Y[q]),
                                 pxy5_ff, DIR_X[q] * DIR_Y[q]);
         end

         for (int q = 0; q < NUM_DIR; q++) begin
            ms7_ff[q] <= mul_raw(mom_ff[5][M00], t6_ff[q]);
            fk7_ff[q] <= mul_raw(kfac(q), s6_ff[q]);
         end

         for (int q = 0; q < NUM_DIR; q++) begin
            ms8_ff[q]  <= mul_fin(ms7_ff[q]);
            f1_8_ff[q] <= mul_fin(fk7_ff[q]);
         end

         for (int q = 0; q < NUM_DIR; q++) begin
            w9_ff[q]  <= mul_raw(weight(q), ms8_ff[q]);
            kf9_ff[q] <= mul_raw(keep, f1_8_ff[q]);
         end

         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

[hw/rtl/d2q9_regularized_bgk_collision_unit.sv]
// D2Q9 regularized BGK collision unit, one lattice cell per transfer.
// Pipeline: 3 moment stages, 18 divider stages, 10 collision stages.
// Throughput: one cell per cycle; a stalled result freezes the whole pipeline.
// Depth is set by the 16-stage restoring divider for the velocity quotients.
// Reset clears all valid bits and sets the relax rate to 1.0.
module d2q9_regularized_bgk_collision_unit import rbgk_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_wen,
   input  logic [RATE_W-1:0] csr_wdata
);

   localparam int CELL_DLY = DIV_LAT + COL_LAT - 1;

   logic     adv;
   logic     v_ff [TOTAL_LAT];
   data_type keep_ff;
   mom_type  mom;
   req_type  cell3;
   mom_type  mom_d_ff [DIV_LAT];
   req_type  cell_d_ff [CELL_DLY];
   data_type ux, uy;

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = v_ff[TOTAL_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TOTAL_LAT; k++) v_ff[k] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= req_valid;
         for (int k = 1; k < TOTAL_LAT; k++) v_ff[k] <= v_ff[k-1];
      end
   end

   // 1 - omega is what the datapath uses
   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff <= KEEP_RESET;
      end else if (csr_wen) begin
         keep_ff <= sat_sub(ONE, data_type'({{(DW-RATE_W){1'b0}}, csr_wdata}));
      end
   end

   rbgk_moments u_moments (
      .clock    (clock),
      .en       (adv),
      .cell_in  (req_data),
      .mom_out  (mom),
      .cell_out (cell3)
   );

   rbgk_divider u_div_x (
      .clock (clock),
      .en    (adv),
      .num   (mom[M10]),
      .den   (mom[M00]),
      .quo   (ux)
   );

   rbgk_divider u_div_y (
      .clock (clock),
      .en    (adv),
      .num   (mom[M01]),
      .den   (mom[M00]),
      .quo   (uy)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         mom_d_ff[0]  <= mom;
         cell_d_ff[0] <= cell3;
         for (int k = 1; k < DIV_LAT; k++) mom_d_ff[k] <= mom_d_ff[k-1];
         for (int k = 1; k < CELL_DLY; k++) cell_d_ff[k] <= cell_d_ff[k-1];
      end
   end

   rbgk_collide u_collide (
      .clock (clock),
      .en    (adv),
      .ux    (ux),
      .uy    (uy),
      .mom   (mom_d_ff[DIV_LAT-1]),
      .keep  (keep_ff),
      .site  (cell_d_ff[CELL_DLY-1]),
      .rsp   (rsp_data)
   );

endmodule

[hw/rtl/rbgk_checker.sv]
// Port-level checker for the collision unit, attached by bind.
// Depends on rbgk_pkg and d2q9_regularized_bgk_collision_unit.
module rbgk_props import rbgk_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // input side is held exactly when a result transfer is blocked
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow output backpressure");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind d2q9_regularized_bgk_collision_unit rbgk_props u_rbgk_props (.*);

[verif/rbgk_checker.sv]
// Checker for the D2Q9 regularized BGK collision unit: watches both channels,
// predicts each post-collision cell in Q4.28 and compares. Depends on rbgk_pkg.
module rbgk_checker import rbgk_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  req_type           req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  rsp_type           rsp_data,
   input  logic              csr_wen,
   input  logic [RATE_W-1:0] csr_wdata,
   output int                fail_count,
   output int                pending
);
   typedef longint signed wide_type;

   localparam wide_type HI = 64'sd2147483647;
   localparam wide_type LO = -64'sd2147483648;

   rsp_type     post_queue[$];
   logic [29:0] omega_reg;

   function automatic wide_type clip(wide_type v);
      if (v > HI) return HI;
      if (v < LO) return LO;
      return v;
   endfunction

   function automatic wide_type qadd(wide_type a, wide_type b);
      return clip(a + b);
   endfunction

   function automatic wide_type qsub(wide_type a, wide_type b);
      return clip(a - b);
   endfunction

   // exact product, rounded half away from zero on magnitude
   function automatic wide_type qmul(wide_type a, wide_type b);
      logic signed [127:0] p;
      logic [127:0]        m;
      logic signed [127:0] r;
      p = 128'(a) * 128'(b);
      m = p < 0 ? -p : p;
      m = (m + (128'd1 << 27)) >> 28;
      r = p < 0 ? -$signed(m) : $signed(m);
      if (r > HI) return HI;
      if (r < LO) return LO;
      return wide_type'(r);
   endfunction

   function automatic wide_type qdiv(wide_type n, wide_type d);
      logic signed [127:0] q;
      if (d == 0) return n > 0 ? HI : (n < 0 ? LO : 0);
      q = (128'(n) <<< 28) / 128'(d);
      if (q > HI) return HI;
      if (q < LO) return LO;
      return wide_type'(q);
   endfunction

   function automatic rsp_type collide(req_type c, logic [29:0] rate);
      dist_type f;
      dist_type p;
      wide_type rho, mx, my, mxy, mxx, myy, ux, uy, uu, pxx, pxy, pyy, keep;
      wide_type eu, t, feq, s, qxx, qyy, w, k;
      f = cell_dist(c);
      if (!c.is_fluid) return make_rsp(1'b0, f);
      rho = 0; mx = 0; my = 0; mxy = 0; mxx = 0; myy = 0;
      for (int q = 0; q < NUM_DIR; q++) begin
         rho = qadd(rho, f[q]);
         if (DIR_X[q] > 0) mx = qadd(mx, f[q]);
         if (DIR_X[q] < 0) mx = qsub(mx, f[q]);
         if (DIR_Y[q] > 0) my = qadd(my, f[q]);
         if (DIR_Y[q] < 0) my = qsub(my, f[q]);
         if (DIR_X[q] * DIR_Y[q] > 0) mxy = qadd(mxy, f[q]);
         if (DIR_X[q] * DIR_Y[q] < 0) mxy = qsub(mxy, f[q]);
         if (DIR_X[q] != 0) mxx = qadd(mxx, f[q]);
         if (DIR_Y[q] != 0) myy = qadd(myy, f[q]);
      end
      ux  = qdiv(mx, rho);
      uy  = qdiv(my, rho);
      uu  = qadd(qmul(ux, ux), qmul(uy, uy));
      pxx = qsub(mxx, qmul(rho, qadd(qmul(ux, ux), 89478485)));
      pxy = qsub(mxy, qmul(rho, qmul(ux, uy)));
      pyy = qsub(myy, qmul(rho, qadd(qmul(uy, uy), 89478485)));
      keep = qsub(268435456, wide_type'(rate) > HI ? HI : wide_type'(rate));
      for (int q = 0; q < NUM_DIR; q++) begin
         w = q == 0 ? 119304647 : (q < 5 ? 29826162 : 7456540);
         k = q == 0 ? 536870912 : (q < 5 ? 134217728 : 33554432);
         eu = 0;
         if (DIR_X[q] > 0) eu = qadd(eu, ux);
         if (DIR_X[q] < 0) eu = qsub(eu, ux);
         if (DIR_Y[q] > 0) eu = qadd(eu, uy);
         if (DIR_Y[q] < 0) eu = qsub(eu, uy);
         t = qadd(268435456, qmul(805306368, eu));
         t = qadd(t, qmul(1207959552, qmul(eu, eu)));
         t = qsub(t, qmul(402653184, uu));
         feq = qmul(w, qmul(rho, t));
         qxx = DIR_X[q] != 0 ? 178956971 : -89478485;
         qyy = DIR_Y[q] != 0 ? 178956971 : -89478485;
         s = qadd(qmul(qxx, pxx), qmul(qyy, pyy));
         if (DIR_X[q] * DIR_Y[q] > 0) s = qadd(qadd(s, pxy), pxy);
         if (DIR_X[q] * DIR_Y[q] < 0) s = qsub(qsub(s, pxy), pxy);
         p[q] = data_type'(qadd(feq, qmul(keep, qmul(k, s))));
      end
      return make_rsp(1'b1, p);
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         omega_reg  <= 30'd268435456;
         fail_count <= 0;
         post_queue.delete();
         pending    <= 0;
      end else begin
         if (csr_wen) omega_reg <= csr_wdata;
         if (req_valid && !req_stall) post_queue.push_back(collide(req_data, omega_reg));
         if (rsp_valid && !rsp_stall) begin
            if (post_queue.size() == 0) begin
               $display("%0t: unexpected transfer, actual %h", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = post_queue.pop_front();
               if (want !== rsp_data) begin
                  $display("%0t: mismatch expected %h actual %h", $time, want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= post_queue.size();
      end
   end
endmodule

[verif/tb.sv]
// Top of the collision unit testbench: clock, reset, stimulus and verdict.
// Depends on rbgk_pkg, the unit and rbgk_checker.
module tb;
   import rbgk_pkg::*;

   localparam int WATCHDOG = 20000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_type           rsp_data;
   logic              csr_wen = 1'b0;
   logic [RATE_W-1:0] csr_wdata = '0;
   int                fail_count;
   int                pending;
   int                idle_cycles = 0;
   bit                quiet = 1'b0;
   bit                long_hold = 1'b0;

   always #10 clock = ~clock;

   d2q9_regularized_bgk_collision_unit dut (.*);
   rbgk_checker chk (.*);

   // random 32-bit value, biased toward extremes and small densities
   function automatic data_type pick_val();
      case ($urandom_range(0, 9))
         0: return MAXV;
         1: return MINV;
         2: return '0;
         3: return data_type'($urandom);
         default: return data_type'($signed($urandom_range(0, 1 << 27)) - (1 << 26));
      endcase
   endfunction

   function automatic req_type pick_cell();
      req_type c;
      c.is_fluid = $urandom_range(0, 7) != 0;
      c.dist_rest = pick_val(); c.dist_east = pick_val(); c.dist_north = pick_val();
      c.dist_west = pick_val(); c.dist_south = pick_val(); c.dist_ne = pick_val();
      c.dist_nw = pick_val(); c.dist_sw = pick_val(); c.dist_se = pick_val();
      if ($urandom_range(0, 1)) begin
         // rest, east and west near their equilibrium weights at unit density
         c.dist_rest = 32'sd119304647 + $signed($urandom_range(0, 1 << 22)) - (1 << 21);
         c.dist_east = 32'sd29826162 + $signed($urandom_range(0, 1 << 22)) - (1 << 21);
         c.dist_west = 32'sd29826162 + $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      end
      return c;
   endfunction

   task automatic send(req_type c, bit gaps);
      if (gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_data  <= c;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_rate(logic [RATE_W-1:0] v);
      csr_wen   <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_wen   <= 1'b0;
   endtask

   // receiver stall: random bursts, one long hold-off, none near the end
   initial begin
      @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (120) @(negedge clock);
            rsp_stall <= 1'b0;
            long_hold = 1'b0;
            @(negedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clock);
            rsp_stall <= 1'b0;
            @(negedge clock);
         end else begin
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (!reset && idle_cycles >= WATCHDOG) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      logic [RATE_W-1:0] rates[4];
      req_type           c;
      rates = '{30'd0, 30'd536870912, 30'h3FFFFFFF, 30'd400000000};
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // directed cells at the default rate
      c = '0; c.is_fluid = 1'b1; send(c, 0);                     // zero density
      c = '{1'b1, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV}; send(c, 0);
      c = '{1'b1, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV}; send(c, 0);
      c = '{1'b0, MAXV, MINV, 0, -1, 1, MAXV, MINV, 5, -5}; send(c, 0);
      c = '{1'b1, 0, 32'sd268435456, 0, 0, 0, 0, 0, 0, 0}; send(c, 0);   // unit density, all moving east
      c = '{1'b1, 0, -32'sd268435456, 0, 0, 0, 0, 0, 0, 0}; send(c, 0);
      c = '{1'b1, 32'sd119304647, 32'sd29826162, 32'sd29826162, 32'sd29826162,
            32'sd29826162, 32'sd7456540, 32'sd7456540, 32'sd7456540, 32'sd7456540};
      send(c, 0);
      c = '{1'b1, 0, 1, 0, -1, 0, 0, 0, 0, 0}; send(c, 0);
      c = '{1'b0, -1, -1, -1, -1, -1, -1, -1, -1, -1}; send(c, 0);
      drain();
      for (int ph = 0; ph < 5; ph++) begin
         write_rate(ph < 4 ? rates[ph] : 30'($urandom_range(0, 536870912)));
         for (int i = 0; i < 350; i++) begin
            if (ph == 1 && i == 50) long_hold = 1'b1;
            if (ph == 2 && i == 100) drain();
            if (ph == 4 && i == 250) quiet = 1'b1;
            send(pick_cell(), !quiet);
         end
         drain();
      end
      if (fail_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
